/* sv/aabb_collision_resolve_assert.svh */
// Assertion macros for the RTL of the collision block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef AABB_COLLISION_RESOLVE_ASSERT_SVH
`define AABB_COLLISION_RESOLVE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AABB_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AABB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/aabb_pkg.sv */
package aabb_pkg;

  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 4;

  // Sums of two coordinates, doubled spans and centre differences, overlaps.
  localparam int SUM_W = COORD_BITS + 1;
  localparam int N2_W  = COORD_BITS + 2;
  localparam int OV_W  = COORD_BITS + 3;

  // Reference max x that selects default mode, in Q format.
  localparam int DEFAULT_MAX_X = -999 * (2 ** FRAC_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [N2_W-1:0]       n2_t;
  typedef logic signed [OV_W-1:0]       ov_t;

  // Clears the fraction bits of a doubled distance, leaving whole pixels.
  localparam logic [N2_W-1:0] WHOLE_MASK = ~N2_W'((2 ** (FRAC_BITS + 1)) - 1);

  localparam coord_t PUSH_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t PUSH_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    SIDE_ZERO = 2'b00,
    SIDE_POS  = 2'b01,
    SIDE_NEG  = 2'b10
  } side_t;

endpackage

/* sv/aabb_axis_ovl.sv */
module aabb_axis_ovl
  import aabb_pkg::*;
(
  input  n2_t n2,
  input  n2_t ext2,
  output ov_t ov
);

  logic [N2_W-1:0] mag;
  logic [N2_W-1:0] whole;

  // The centre distance is truncated to whole pixels before it is taken off.
  assign mag   = n2[N2_W-1] ? N2_W'(-n2) : N2_W'(n2);
  assign whole = mag & WHOLE_MASK;
  assign ov    = ov_t'(ext2) - ov_t'({1'b0, whole});

endmodule

/* sv/aabb_collision_resolve.sv */
// Push-out resolver for a moving box against an obstacle box. One beat is accepted on every
// clock (busy stays low), and its result appears on the out_ ports, marked by out_valid for
// exactly one cycle. It passes four register stages: edge tests and sums, per-axis overlap,
// side selection, then negation and saturation. The receiver cannot stall the block, so
// every out_valid beat must be taken as it comes.
`include "aabb_collision_resolve_assert.svh"

module aabb_collision_resolve
  import aabb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  coord_t in_mover_min_x,
  input  coord_t in_mover_min_y,
  input  coord_t in_mover_max_x,
  input  coord_t in_mover_max_y,
  input  coord_t in_obstacle_min_x,
  input  coord_t in_obstacle_min_y,
  input  coord_t in_obstacle_max_x,
  input  coord_t in_obstacle_max_y,
  input  coord_t in_ref_min_x,
  input  coord_t in_ref_min_y,
  input  coord_t in_ref_max_x,
  input  coord_t in_ref_max_y,
  output logic   out_valid,
  output coord_t out_push_x,
  output coord_t out_push_y,
  output logic   out_overlapping
);

  function automatic sum_t csum(coord_t a, coord_t b);
    return sum_t'(a) + sum_t'(b);
  endfunction

  function automatic sum_t dbl(coord_t a);
    return sum_t'(a) <<< 1;
  endfunction

  function automatic n2_t span2(coord_t lo, coord_t hi);
    return n2_t'(sum_t'(hi) - sum_t'(lo));
  endfunction

  function automatic coord_t finish(ov_t q, side_t s);
    ov_t    neg;
    coord_t res;
    neg = -q;
    unique case (s)
      SIDE_POS: res = (q > ov_t'(PUSH_MAX)) ? PUSH_MAX : coord_t'(q);
      SIDE_NEG: res = (neg < ov_t'(PUSH_MIN)) ? PUSH_MIN : coord_t'(neg);
      SIDE_ZERO: res = '0;
      default: res = '0;
    endcase
    return res;
  endfunction

  // Stage 1: overlap test, centre differences, extents, mode and reference sides.
  logic  hit_nxt, dflt_nxt;
  n2_t   nx2_nxt, ny2_nxt, extx_nxt, exty_nxt;
  side_t sxr_nxt, syr_nxt;

  logic  v1_r, hit1_r, dflt1_r;
  n2_t   nx2_1_r, ny2_1_r, extx1_r, exty1_r;
  side_t sxr1_r, syr1_r;

  // Stage 2: clamped doubled overlaps.
  ov_t   ovx, ovy, ox_nxt, oy_nxt;
  logic  v2_r, hit2_r, dflt2_r, nxneg2_r, nyneg2_r;
  ov_t   ox2_r, oy2_r;
  side_t sxr2_r, syr2_r;

  // Stage 3: chosen sides and halved magnitudes.
  side_t sx_nxt, sy_nxt;
  logic  v3_r, hit3_r;
  ov_t   qx3_r, qy3_r;
  side_t sx3_r, sy3_r;

  // Stage 4: output registers.
  logic   out_valid_r, out_overlapping_r;
  coord_t out_push_x_r, out_push_y_r;

  assign hit_nxt = !(in_mover_max_x < in_obstacle_min_x || in_mover_min_x > in_obstacle_max_x)
                && !(in_mover_max_y < in_obstacle_min_y || in_mover_min_y > in_obstacle_max_y);
  assign nx2_nxt = n2_t'(csum(in_obstacle_min_x, in_obstacle_max_x))
                 - n2_t'(csum(in_mover_min_x, in_mover_max_x));
  assign ny2_nxt = n2_t'(csum(in_obstacle_min_y, in_obstacle_max_y))
                 - n2_t'(csum(in_mover_min_y, in_mover_max_y));
  assign extx_nxt = span2(in_mover_min_x, in_mover_max_x)
                  + span2(in_obstacle_min_x, in_obstacle_max_x);
  assign exty_nxt = span2(in_mover_min_y, in_mover_max_y)
                  + span2(in_obstacle_min_y, in_obstacle_max_y);
  assign dflt_nxt = (32'(in_ref_max_x) == DEFAULT_MAX_X);

  // A strict x overlap with the reference decides the y side; failing that, y decides x.
  always_comb begin
    sxr_nxt = SIDE_ZERO;
    syr_nxt = SIDE_ZERO;
    if (in_obstacle_max_x > in_ref_min_x && in_obstacle_min_x < in_ref_max_x) begin
      if (dbl(in_ref_max_y) < csum(in_obstacle_min_y, in_obstacle_max_y)) begin
        syr_nxt = SIDE_POS;
      end else if (dbl(in_ref_min_y) > csum(in_obstacle_min_y, in_obstacle_max_y)) begin
        syr_nxt = SIDE_NEG;
      end
    end else if (in_obstacle_max_y > in_ref_min_y && in_obstacle_min_y < in_ref_max_y) begin
      if (dbl(in_ref_max_x) < csum(in_obstacle_min_x, in_obstacle_max_x)) begin
        sxr_nxt = SIDE_POS;
      end else if (dbl(in_ref_min_x) > csum(in_obstacle_min_x, in_obstacle_max_x)) begin
        sxr_nxt = SIDE_NEG;
      end
    end
  end

  aabb_axis_ovl u_ovl_x (
    .n2   (nx2_1_r),
    .ext2 (extx1_r),
    .ov   (ovx)
  );

  aabb_axis_ovl u_ovl_y (
    .n2   (ny2_1_r),
    .ext2 (exty1_r),
    .ov   (ovy)
  );

  // A miss or a negative x overlap zeroes both axes; a negative y overlap zeroes only y.
  assign ox_nxt = (!hit1_r || ovx[OV_W-1]) ? '0 : ovx;
  assign oy_nxt = (!hit1_r || ovx[OV_W-1] || ovy[OV_W-1]) ? '0 : ovy;

  // Default mode keeps the smaller axis; on a tie y is kept.
  always_comb begin
    if (dflt2_r) begin
      if (ox2_r < oy2_r) begin
        sx_nxt = nxneg2_r ? SIDE_NEG : SIDE_POS;
        sy_nxt = SIDE_ZERO;
      end else begin
        sx_nxt = SIDE_ZERO;
        sy_nxt = nyneg2_r ? SIDE_NEG : SIDE_POS;
      end
    end else begin
      sx_nxt = sxr2_r;
      sy_nxt = syr2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    hit1_r  <= hit_nxt;
    dflt1_r <= dflt_nxt;
    nx2_1_r <= nx2_nxt;
    ny2_1_r <= ny2_nxt;
    extx1_r <= extx_nxt;
    exty1_r <= exty_nxt;
    sxr1_r  <= sxr_nxt;
    syr1_r  <= syr_nxt;

    hit2_r   <= hit1_r;
    dflt2_r  <= dflt1_r;
    nxneg2_r <= nx2_1_r[N2_W-1];
    nyneg2_r <= ny2_1_r[N2_W-1];
    ox2_r    <= ox_nxt;
    oy2_r    <= oy_nxt;
    sxr2_r   <= sxr1_r;
    syr2_r   <= syr1_r;

    hit3_r <= hit2_r;
    qx3_r  <= ox2_r >>> 1;
    qy3_r  <= oy2_r >>> 1;
    sx3_r  <= sx_nxt;
    sy3_r  <= sy_nxt;

    out_overlapping_r <= hit3_r;
    out_push_x_r      <= finish(qx3_r, sx3_r);
    out_push_y_r      <= finish(qy3_r, sy3_r);
  end

  assign busy            = 1'b0;
  assign out_valid       = out_valid_r;
  assign out_push_x      = out_push_x_r;
  assign out_push_y      = out_push_y_r;
  assign out_overlapping = out_overlapping_r;

  `AABB_CHECK(a_latency, out_valid_r, $past(start, 4), "result beat without a start beat four cycles earlier")
  `AABB_CHECK(a_ovl_clamped, v2_r, !ox2_r[OV_W-1] && !oy2_r[OV_W-1], "negative overlap escaped the clamp")
  `AABB_CHECK_NEXT(a_miss_zero, v3_r && !hit3_r, out_push_x == '0 && out_push_y == '0 && !out_overlapping, "non-overlapping pair gave a push")

endmodule
